[hw/rtl/xoshiro256ss_four_lane_generator_defines.svh]
// Assertion macros for the four-lane generator.
`ifndef XOSHIRO256SS_FOUR_LANE_GENERATOR_DEFINES_SVH
`define XOSHIRO256SS_FOUR_LANE_GENERATOR_DEFINES_SVH

// Same-cycle implication, held off while in reset.
`define XSS4_ASSERT_IMPLY(label, clk, rst_n, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_now)) else $error("xss4 check failed");

// Next-cycle implication, held off while in reset.
`define XSS4_ASSERT_NEXT(label, clk, rst_n, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error("xss4 check failed");

`endif

[hw/rtl/xss4_pkg.sv]
package xss4_pkg;

    localparam int LANES_DEFAULT = 4;
    localparam int OUT_LANES     = 4;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_ONE = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_TWO = 64'h94d049bb133111eb;
    localparam logic [10:0] EXP_TOP     = 11'd1022;

    localparam logic [1:0] CMD_SEED = 2'd0;
    localparam logic [1:0] CMD_INT  = 2'd1;
    localparam logic [1:0] CMD_DBL  = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] lane_count;
    } req_t;

    typedef struct packed {
        logic [63:0] lane_zero;
        logic [63:0] lane_one;
        logic [63:0] lane_two;
        logic [63:0] lane_three;
        logic        is_double;
    } res_t;

    typedef enum logic [1:0] {
        OP_SEED,
        OP_INT,
        OP_DBL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] limit;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_PRE,
        ST_SEED_MUL,
        ST_SEED_POST,
        ST_ADV,
        ST_NORM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [51:0] mant;
        logic [5:0]  shift;
    } norm_t;

    function automatic logic [63:0] lane_output(input logic [63:0] b);
        logic [63:0] t5;
        logic [63:0] r;
        t5 = b + (b << 2);
        r  = {t5[56:0], t5[63:57]};
        return r + (r << 3);
    endfunction

    function automatic norm_t norm_step(input norm_t cur, input logic [2:0] step);
        norm_t nxt;
        nxt = cur;
        unique case (step)
            3'd0:
            begin
                if (cur.mant[51:20] == '0)
                begin
                    nxt.mant  = cur.mant << 32;
                    nxt.shift = cur.shift + 6'd32;
                end
            end
            3'd1:
            begin
                if (cur.mant[51:36] == '0)
                begin
                    nxt.mant  = cur.mant << 16;
                    nxt.shift = cur.shift + 6'd16;
                end
            end
            3'd2:
            begin
                if (cur.mant[51:44] == '0)
                begin
                    nxt.mant  = cur.mant << 8;
                    nxt.shift = cur.shift + 6'd8;
                end
            end
            3'd3:
            begin
                if (cur.mant[51:48] == '0)
                begin
                    nxt.mant  = cur.mant << 4;
                    nxt.shift = cur.shift + 6'd4;
                end
            end
            3'd4:
            begin
                if (cur.mant[51:50] == '0)
                begin
                    nxt.mant  = cur.mant << 2;
                    nxt.shift = cur.shift + 6'd2;
                end
            end
            3'd5:
            begin
                if (!cur.mant[51])
                begin
                    nxt.mant  = cur.mant << 1;
                    nxt.shift = cur.shift + 6'd1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        return nxt;
    endfunction

endpackage

[hw/rtl/xss4_front.sv]
module xss4_front #(
    parameter int LANES = xss4_pkg::LANES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  xss4_pkg::req_t    cmd_data,
    output xss4_pkg::head_t   head,
    input  logic              pop
);

    localparam int NOUT = (LANES < xss4_pkg::OUT_LANES) ? LANES : xss4_pkg::OUT_LANES;
    localparam int QAW  = (xss4_pkg::QUEUE_DEPTH > 1) ? $clog2(xss4_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW  = $clog2(xss4_pkg::QUEUE_DEPTH + 1);

    xss4_pkg::job_t q_reg [xss4_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QCW-1:0] cnt_reg;
    logic [QCW-1:0] cnt_next;

    logic           keep;
    logic           push;
    xss4_pkg::job_t job_in;

    // classify
    always_comb
    begin
        keep      = 1'b1;
        job_in.op = xss4_pkg::OP_INT;
        job_in.limit = (cmd_data.lane_count > 3'(NOUT)) ? 3'(NOUT) : cmd_data.lane_count;
        unique case (cmd_data.command)
            xss4_pkg::CMD_SEED: job_in.op = xss4_pkg::OP_SEED;
            xss4_pkg::CMD_INT:  job_in.op = xss4_pkg::OP_INT;
            xss4_pkg::CMD_DBL:  job_in.op = xss4_pkg::OP_DBL;
            default:            keep = 1'b0; // drop unused code
        endcase
    end

    assign cmd_ready = (cnt_reg != QCW'(xss4_pkg::QUEUE_DEPTH));
    assign push      = cmd_valid && cmd_ready && keep;

    assign head.valid = (cnt_reg != '0);
    assign head.job   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

[hw/rtl/xss4_back.sv]
module xss4_back #(
    parameter int LANES = xss4_pkg::LANES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  xss4_pkg::head_t   head,
    output logic              pop,
    input  logic              seed_valid,
    output logic              seed_ready,
    input  logic [63:0]       seed_data,
    output logic              res_valid,
    input  logic              res_ready,
    output xss4_pkg::res_t    res_data
);

    localparam int NOUT = (LANES < xss4_pkg::OUT_LANES) ? LANES : xss4_pkg::OUT_LANES;
    localparam int LIW  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int NO   = xss4_pkg::OUT_LANES;

    localparam logic [1:0] PART_LOW  = 2'd0;
    localparam logic [1:0] PART_HI_A = 2'd1;
    localparam logic [1:0] PART_HI_K = 2'd2;
    localparam logic [2:0] NORM_LAST = 3'd5;
    localparam logic [1:0] WORD_A    = 2'd0;
    localparam logic [1:0] WORD_B    = 2'd1;
    localparam logic [1:0] WORD_C    = 2'd2;
    localparam logic [1:0] WORD_D    = 2'd3;

    xss4_pkg::state_t state_reg;
    xss4_pkg::state_t state_next;

    logic [63:0]    seed_reg;
    logic [63:0]    mix_reg;
    logic [63:0]    z_reg;
    logic [63:0]    acc_reg;
    logic           round_reg;
    logic [1:0]     part_reg;
    logic [LIW-1:0] lane_reg;
    logic [1:0]     word_reg;
    logic [2:0]     nstep_reg;
    logic           dbl_reg;
    logic [2:0]     limit_reg;

    logic [63:0] wa_reg [LANES];
    logic [63:0] wb_reg [LANES];
    logic [63:0] wc_reg [LANES];
    logic [63:0] wd_reg [LANES];

    logic [63:0]      res_reg [NO];
    xss4_pkg::norm_t  nm_reg  [NO];
    xss4_pkg::res_t   out_reg;
    xss4_pkg::res_t   out_next;
    logic             out_valid_reg;

    logic        out_free;
    logic        do_pre;
    logic        do_mul;
    logic        do_post;
    logic        do_adv;
    logic        do_norm;
    logic        do_emit;
    logic        mul_last;
    logic        seed_last;
    logic        last_lane;

    logic [63:0] mix_sum;
    logic [63:0] mul_k;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] acc_sum;
    logic [63:0] mix_out;

    logic [63:0] lane_val [NO];
    logic [63:0] lane_fin [NO];

    assign seed_ready = 1'b1;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_reg;
    assign out_free   = !out_valid_reg || res_ready;

    assign mul_last  = round_reg && (part_reg == PART_HI_K);
    assign last_lane = (lane_reg == LIW'(LANES - 1));
    assign seed_last = (word_reg == WORD_D) && last_lane;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xss4_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = (head.job.op == xss4_pkg::OP_SEED) ?
                                 xss4_pkg::ST_SEED_PRE : xss4_pkg::ST_ADV;
                end
            end
            xss4_pkg::ST_SEED_PRE:
            begin
                state_next = xss4_pkg::ST_SEED_MUL;
            end
            xss4_pkg::ST_SEED_MUL:
            begin
                if (mul_last)
                begin
                    state_next = xss4_pkg::ST_SEED_POST;
                end
            end
            xss4_pkg::ST_SEED_POST:
            begin
                state_next = seed_last ? xss4_pkg::ST_IDLE : xss4_pkg::ST_SEED_PRE;
            end
            xss4_pkg::ST_ADV:
            begin
                state_next = dbl_reg ? xss4_pkg::ST_NORM : xss4_pkg::ST_EMIT;
            end
            xss4_pkg::ST_NORM:
            begin
                if (nstep_reg == NORM_LAST)
                begin
                    state_next = xss4_pkg::ST_EMIT;
                end
            end
            xss4_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = xss4_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xss4_pkg::ST_IDLE;
            end
        endcase
    end

    // control strobes
    always_comb
    begin
        pop     = 1'b0;
        do_pre  = 1'b0;
        do_mul  = 1'b0;
        do_post = 1'b0;
        do_adv  = 1'b0;
        do_norm = 1'b0;
        do_emit = 1'b0;
        unique case (state_reg)
            xss4_pkg::ST_IDLE:      pop     = head.valid;
            xss4_pkg::ST_SEED_PRE:  do_pre  = 1'b1;
            xss4_pkg::ST_SEED_MUL:  do_mul  = 1'b1;
            xss4_pkg::ST_SEED_POST: do_post = 1'b1;
            xss4_pkg::ST_ADV:       do_adv  = 1'b1;
            xss4_pkg::ST_NORM:      do_norm = 1'b1;
            xss4_pkg::ST_EMIT:      do_emit = out_free;
            default:                pop     = 1'b0;
        endcase
    end

    // shared 32x32 multiplier for the splitmix64 rounds
    always_comb
    begin
        mix_sum = mix_reg + xss4_pkg::GOLDEN_STEP;
        mul_k   = round_reg ? xss4_pkg::MIX_MUL_TWO : xss4_pkg::MIX_MUL_ONE;
        mul_a   = (part_reg == PART_HI_A) ? z_reg[63:32] : z_reg[31:0];
        mul_b   = (part_reg == PART_HI_K) ? mul_k[63:32] : mul_k[31:0];
        prod    = 64'(mul_a) * 64'(mul_b);
        acc_sum = (part_reg == PART_LOW) ? prod : acc_reg + {prod[31:0], 32'd0};
        mix_out = acc_reg ^ (acc_reg >> 31);
    end

    for (genvar o = 0; o < NO; o++)
    begin : g_out
        if (o < NOUT)
        begin : g_lane
            assign lane_val[o] = xss4_pkg::lane_output(wb_reg[o]);
        end
        else
        begin : g_none
            assign lane_val[o] = '0;
        end
        assign lane_fin[o] = !dbl_reg ? res_reg[o] :
                             (nm_reg[o].mant == '0) ? 64'd0 :
                             {1'b0, xss4_pkg::EXP_TOP - 11'(nm_reg[o].shift),
                              nm_reg[o].mant[50:0], 1'b0};
    end

    always_comb
    begin
        out_next.lane_zero  = lane_fin[0];
        out_next.lane_one   = lane_fin[1];
        out_next.lane_two   = lane_fin[2];
        out_next.lane_three = lane_fin[3];
        out_next.is_double  = dbl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xss4_pkg::ST_IDLE;
            seed_reg      <= '0;
            mix_reg       <= '0;
            round_reg     <= 1'b0;
            part_reg      <= PART_LOW;
            lane_reg      <= '0;
            word_reg      <= WORD_A;
            nstep_reg     <= '0;
            dbl_reg       <= 1'b0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (seed_valid && seed_ready)
            begin
                seed_reg <= seed_data;
            end
            if (pop)
            begin
                dbl_reg   <= (head.job.op == xss4_pkg::OP_DBL);
                limit_reg <= head.job.limit;
                lane_reg  <= '0;
                word_reg  <= WORD_A;
                mix_reg   <= seed_reg;
            end
            if (do_pre)
            begin
                mix_reg   <= mix_sum;
                round_reg <= 1'b0;
                part_reg  <= PART_LOW;
            end
            if (do_mul)
            begin
                if (part_reg == PART_HI_K)
                begin
                    part_reg  <= PART_LOW;
                    round_reg <= 1'b1;
                end
                else
                begin
                    part_reg <= part_reg + 2'd1;
                end
            end
            if (do_post)
            begin
                if (last_lane)
                begin
                    lane_reg <= '0;
                    word_reg <= word_reg + 2'd1;
                end
                else
                begin
                    lane_reg <= lane_reg + LIW'(1);
                end
            end
            if (do_adv)
            begin
                nstep_reg <= '0;
            end
            if (do_norm)
            begin
                nstep_reg <= nstep_reg + 3'd1;
            end
            if (do_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pre)
        begin
            z_reg <= mix_sum ^ (mix_sum >> 30);
        end
        if (do_mul)
        begin
            acc_reg <= acc_sum;
            if (part_reg == PART_HI_K && !round_reg)
            begin
                z_reg <= acc_sum ^ (acc_sum >> 27);
            end
        end
        if (do_adv)
        begin
            for (int o = 0; o < NO; o++)
            begin
                res_reg[o]        <= (3'(o) < limit_reg) ? lane_val[o] : 64'd0;
                nm_reg[o].mant    <= (3'(o) < limit_reg) ? lane_val[o][63:12] : 52'd0;
                nm_reg[o].shift   <= '0;
            end
        end
        if (do_norm)
        begin
            for (int o = 0; o < NO; o++)
            begin
                nm_reg[o] <= xss4_pkg::norm_step(nm_reg[o], nstep_reg);
            end
        end
        if (do_emit)
        begin
            out_reg <= out_next;
        end
    end

    // generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                wa_reg[l] <= '0;
                wb_reg[l] <= '0;
                wc_reg[l] <= '0;
                wd_reg[l] <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (do_adv)
                begin
                    wa_reg[l] <= wa_reg[l] ^ wd_reg[l] ^ wb_reg[l];
                    wb_reg[l] <= wb_reg[l] ^ wc_reg[l] ^ wa_reg[l];
                    wc_reg[l] <= wc_reg[l] ^ wa_reg[l] ^ (wb_reg[l] << 17);
                    wd_reg[l] <= {wd_reg[l][18:0] ^ wb_reg[l][18:0],
                                  wd_reg[l][63:19] ^ wb_reg[l][63:19]};
                end
                else if (do_post && lane_reg == LIW'(l))
                begin
                    unique case (word_reg)
                        WORD_A: wa_reg[l] <= mix_out;
                        WORD_B: wb_reg[l] <= mix_out;
                        WORD_C: wc_reg[l] <= mix_out;
                        WORD_D: wd_reg[l] <= mix_out;
                    endcase
                end
            end
        end
    end

endmodule

[hw/rtl/xoshiro256ss_four_lane_generator.sv]
// Channel  Handshake                   Payload
// cmd      cmd_valid / cmd_ready       cmd_data  (command, lane_count)
// res      res_valid / res_ready       res_data  (four lanes, is_double)
// seed     seed_valid / seed_ready     seed_data (64-bit seed)
//
// Integer request: pop, ADV, EMIT; uniform request: pop, ADV, six-step normaliser (NORM), EMIT.
// Reseed: SEED_PRE, SEED_MUL, SEED_POST for each word of each lane, on one shared 32x32 multiplier.
// A two-entry request queue keeps cmd_ready high until two requests wait behind the back end.
// Reset zeroes all generator state; reseed before generating.
// A result held on res waits for res_ready; the back end stalls on it only at emit.
`include "xoshiro256ss_four_lane_generator_defines.svh"

module xoshiro256ss_four_lane_generator #(
    parameter int LANES = xss4_pkg::LANES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  xss4_pkg::req_t    cmd_data,
    output logic              res_valid,
    input  logic              res_ready,
    output xss4_pkg::res_t    res_data,
    input  logic              seed_valid,
    output logic              seed_ready,
    input  logic [63:0]       seed_data
);

    xss4_pkg::head_t head;
    logic            pop;

    xss4_front #(
        .LANES (LANES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .head      (head),
        .pop       (pop)
    );

    xss4_back #(
        .LANES (LANES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .seed_valid (seed_valid),
        .seed_ready (seed_ready),
        .seed_data  (seed_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    `XSS4_ASSERT_IMPLY(a_lane0_below_one, clk, rst_n,
        res_valid && res_data.is_double, res_data.lane_zero[63:62] == 2'b00)
    `XSS4_ASSERT_IMPLY(a_lane3_below_one, clk, rst_n,
        res_valid && res_data.is_double, res_data.lane_three[63:62] == 2'b00)
    `XSS4_ASSERT_IMPLY(a_stall_means_queued, clk, rst_n, !cmd_ready, head.valid)
    `XSS4_ASSERT_NEXT(a_single_pop, clk, rst_n, pop, !pop)

endmodule
